/* src/assert_macros.svh */
// Shared assertion macros for the presence table checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CDPT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies a condition in the next.
`define CDPT_ASSERT_NEXT(name, clk, rst_n, cond, nxt, msg) \
    `CDPT_ASSERT(name, clk, rst_n, (cond) |=> (nxt), msg)

`endif

/* src/cdpt_pkg.sv */
package cdpt_pkg;

    localparam int EXT_W = 64;
    localparam int NET_W = 16;
    localparam int IDX_OUT_W = 5;

    // One table entry as it sits in the memory.
    typedef struct packed {
        logic [EXT_W-1:0] ext_addr;
        logic [NET_W-1:0] net_addr;
        logic             seen;
        logic             online;
    } entry_t;

    // One result item.
    typedef struct packed {
        logic                 kind;
        logic [IDX_OUT_W-1:0] entry_index;
        logic                 entry_valid;
        logic                 newly_joined;
        logic                 table_full;
        logic                 is_online;
        logic [EXT_W-1:0]     entry_ext_addr;
        logic [NET_W-1:0]     entry_net_addr;
        logic                 last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SWEEP,
        ST_REPORT
    } state_t;

    localparam logic FUNC_REPORT = 1'b0;
    localparam logic FUNC_SWEEP  = 1'b1;

endpackage

/* src/cdpt_if.sv */
// Request channel: one report or sweep item.
interface cdpt_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [cdpt_pkg::EXT_W-1:0]  ext_addr;
    logic [cdpt_pkg::NET_W-1:0]  net_addr;

    modport source (output valid, func, ext_addr, net_addr, input ready);
    modport sink (input valid, func, ext_addr, net_addr, output ready);
endinterface

// Response channel: one entry status or report answer.
interface cdpt_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [cdpt_pkg::IDX_OUT_W-1:0]  entry_index;
    logic                            entry_valid;
    logic                            newly_joined;
    logic                            table_full;
    logic                            is_online;
    logic [cdpt_pkg::EXT_W-1:0]      entry_ext_addr;
    logic [cdpt_pkg::NET_W-1:0]      entry_net_addr;
    logic                            last;

    modport source (output valid, kind, entry_index, entry_valid, newly_joined, table_full,
                    is_online, entry_ext_addr, entry_net_addr, last, input ready);
    modport sink (input valid, kind, entry_index, entry_valid, newly_joined, table_full,
                  is_online, entry_ext_addr, entry_net_addr, last, output ready);
endinterface

/* src/child_device_presence_table.sv */
// Channel | Dir | Payload                                   | Handshake
// req     | in  | func, ext_addr, net_addr                  | valid/ready
// rsp     | out | kind, entry_index, entry_valid, newly_joined, table_full,
//         |     | is_online, entry_ext_addr, entry_net_addr, last | valid/ready
//
// One item at a time; the search reads one entry per cycle from the entry memory.
// A report search stops at the matching slot; a miss appends a new entry, or is rejected
// when the table is full. A report or sweep on an empty table skips the search.
// A sweep does one read-modify-write per entry.
// Reset clears the fill count and control state; entry contents are not cleared.
// The search runs on under a stalled rsp; the answer and each sweep step wait while the output
// register holds an item that rsp has not taken.
module child_device_presence_table #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    cdpt_req_if.sink    req,
    cdpt_rsp_if.source  rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Entry memory: one write and one registered read per cycle.
    cdpt_pkg::entry_t mem [MAX_ENTRIES];
    cdpt_pkg::entry_t rd_q;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    cdpt_pkg::entry_t wr_data;

    // Control state.
    cdpt_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             func_reg, func_next;
    logic             fresh_reg, fresh_next;   // report appends a new entry
    logic             rej_reg, rej_next;       // answer names no entry
    logic             rsp_valid_reg, rsp_valid_next;

    // Payload.
    logic [cdpt_pkg::EXT_W-1:0] ext_reg;
    logic [cdpt_pkg::NET_W-1:0] net_reg;
    cdpt_pkg::result_t          rsp_reg;

    logic              load_in;
    logic              res_load;
    cdpt_pkg::result_t res_data;
    logic              out_free;
    logic [CNT_W-1:0]  idx_plus1;
    logic              is_last;
    logic              is_match;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign idx_plus1 = CNT_W'(idx_reg) + CNT_W'(1);
    assign is_last   = (idx_plus1 == count_reg);
    assign is_match  = (rd_q.ext_addr == ext_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        func_next  = func_reg;
        fresh_next = fresh_reg;
        rej_next   = rej_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg + IDX_W'(1);
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = '0;
        load_in    = 1'b0;
        res_load   = 1'b0;
        res_data   = '0;
        req.ready  = 1'b0;

        unique case (state_reg)
            cdpt_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    load_in    = 1'b1;
                    func_next  = req.func;
                    idx_next   = '0;
                    fresh_next = 1'b0;
                    rej_next   = 1'b0;
                    if (count_reg == '0)
                    begin
                        // empty table: sweep answers with no entry, report appends slot 0
                        if (req.func == cdpt_pkg::FUNC_SWEEP)
                            rej_next = 1'b1;
                        else
                            fresh_next = 1'b1;
                        state_next = cdpt_pkg::ST_REPORT;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        state_next = (req.func == cdpt_pkg::FUNC_SWEEP) ?
                                     cdpt_pkg::ST_SWEEP : cdpt_pkg::ST_SEARCH;
                    end
                end
            end

            cdpt_pkg::ST_SEARCH:
            begin
                // rd_q holds entry idx_reg; prefetch the next one
                if (is_match)
                begin
                    state_next = cdpt_pkg::ST_REPORT;
                end
                else if (is_last)
                begin
                    if (count_reg == CNT_W'(MAX_ENTRIES))
                    begin
                        rej_next = 1'b1;
                        idx_next = '0;
                    end
                    else
                    begin
                        fresh_next = 1'b1;
                        idx_next   = IDX_W'(count_reg);
                    end
                    state_next = cdpt_pkg::ST_REPORT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            cdpt_pkg::ST_SWEEP:
            begin
                if (out_free)
                begin
                    // seen entries go online and drop seen; others go offline
                    wr_en            = 1'b1;
                    wr_data          = rd_q;
                    wr_data.seen     = 1'b0;
                    wr_data.online   = rd_q.seen;
                    res_load             = 1'b1;
                    res_data.kind        = cdpt_pkg::FUNC_SWEEP;
                    res_data.entry_index = cdpt_pkg::IDX_OUT_W'(idx_reg);
                    res_data.entry_valid = 1'b1;
                    res_data.is_online   = rd_q.seen;
                    res_data.entry_ext_addr = rd_q.ext_addr;
                    res_data.entry_net_addr = rd_q.net_addr;
                    res_data.last        = is_last;
                    if (is_last)
                    begin
                        state_next = cdpt_pkg::ST_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            cdpt_pkg::ST_REPORT:
            begin
                if (out_free)
                begin
                    res_load             = 1'b1;
                    res_data.kind        = func_reg;
                    res_data.entry_index = cdpt_pkg::IDX_OUT_W'(idx_reg);
                    res_data.entry_valid = !rej_reg;
                    res_data.newly_joined = fresh_reg;
                    res_data.table_full  = rej_reg && (func_reg == cdpt_pkg::FUNC_REPORT);
                    res_data.is_online   = !rej_reg;
                    res_data.entry_ext_addr = rej_reg ? '0 : ext_reg;
                    res_data.entry_net_addr = rej_reg ? '0 : net_reg;
                    res_data.last        = 1'b1;
                    if (!rej_reg)
                    begin
                        wr_en            = 1'b1;
                        wr_data.ext_addr = ext_reg;
                        wr_data.net_addr = net_reg;
                        wr_data.seen     = 1'b1;
                        wr_data.online   = 1'b1;
                    end
                    if (fresh_reg)
                        count_next = count_reg + CNT_W'(1);
                    state_next = cdpt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cdpt_pkg::ST_IDLE;
            end
        endcase

        rsp_valid_next = res_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdpt_pkg::ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            func_reg      <= 1'b0;
            fresh_reg     <= 1'b0;
            rej_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            func_reg      <= func_next;
            fresh_reg     <= fresh_next;
            rej_reg       <= rej_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the reported addresses and the outgoing item.
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            ext_reg <= req.ext_addr;
            net_reg <= req.net_addr;
        end
        if (res_load)
            rsp_reg <= res_data;
    end

    // Entry memory; read and write never hit the same slot in one cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_q <= mem[rd_addr];
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.kind           = rsp_reg.kind;
    assign rsp.entry_index    = rsp_reg.entry_index;
    assign rsp.entry_valid    = rsp_reg.entry_valid;
    assign rsp.newly_joined   = rsp_reg.newly_joined;
    assign rsp.table_full     = rsp_reg.table_full;
    assign rsp.is_online      = rsp_reg.is_online;
    assign rsp.entry_ext_addr = rsp_reg.entry_ext_addr;
    assign rsp.entry_net_addr = rsp_reg.entry_net_addr;
    assign rsp.last           = rsp_reg.last;

endmodule

/* src/cdpt_checker.sv */
`include "assert_macros.svh"

module cdpt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic                            rsp_kind,
    input logic [cdpt_pkg::IDX_OUT_W-1:0]  rsp_entry_index,
    input logic                            rsp_entry_valid,
    input logic                            rsp_table_full,
    input logic                            rsp_last
);

    // stalled response keeps its item
    `CDPT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry_index), "rsp dropped or changed while stalled")

    // one item at a time: busy right after an accept
    `CDPT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready, "accepted a second item while busy")

    // a rejection is a single answer naming no entry
    `CDPT_ASSERT(a_full_answer, clk, rst_n, rsp_valid && rsp_table_full |-> rsp_last && !rsp_entry_valid && !rsp_kind, "malformed table-full answer")

    // a report answer is always the only result of its item
    `CDPT_ASSERT(a_report_single, clk, rst_n, rsp_valid && !rsp_kind |-> rsp_last, "report answer without last")

endmodule

bind child_device_presence_table cdpt_checker u_cdpt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_kind        (rsp.kind),
    .rsp_entry_index (rsp.entry_index),
    .rsp_entry_valid (rsp.entry_valid),
    .rsp_table_full  (rsp.table_full),
    .rsp_last        (rsp.last)
);
